// ===== rtl/adsr_envelope_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// adsr_envelope_evaluator_defines.svh
// Assertion macros shared by the envelope evaluator modules.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_EVALUATOR_DEFINES_SVH
`define ADSR_ENVELOPE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ADSR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("adsr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ADSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("adsr: next-cycle check failed");

`endif

// ===== rtl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Phase codes, register indexes and fixed constants of the envelope evaluator.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // Width of the phase code on the result channel
    localparam int PHASE_W = 3;

    // Width of the configuration register index
    localparam int CFG_ADDR_W = 3;

    // Reset value of the attack and sustain levels (one half of full scale, Q0.16 at AMP_BITS = 16)
    localparam logic [31:0] HALF_SCALE = 32'h0000_8000;

    // Envelope phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_DELAY    = 3'd0,
        PH_ATTACK   = 3'd1,
        PH_DECAY    = 3'd2,
        PH_SUSTAIN  = 3'd3,
        PH_RELEASE  = 3'd4,
        PH_FINISHED = 3'd5
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DELAY_END      = 3'd0,
        REG_DELAY_LEVEL    = 3'd1,
        REG_ATTACK_END     = 3'd2,
        REG_ATTACK_LEVEL   = 3'd3,
        REG_DECAY_END      = 3'd4,
        REG_SUSTAIN_LEVEL  = 3'd5,
        REG_RELEASE_LENGTH = 3'd6,
        REG_RELEASE_LEVEL  = 3'd7
    } cfg_reg_t;

endpackage

// ===== rtl/adsr_front.sv =====
// ----------------------------------------------------------------------------
// adsr_front
// Phase decode: picks the envelope segment and forms ramp start, step
// magnitude and direction, numerator and denominator for one transaction.
// ----------------------------------------------------------------------------
`include "adsr_envelope_evaluator_defines.svh"

module adsr_front #(
    parameter int TIME_BITS = 24,
    parameter int AMP_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // upstream side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_BITS-1:0]  in_time,
    input  logic [TIME_BITS-1:0]  in_length,
    // breakpoints and levels
    input  logic [TIME_BITS-1:0]  delay_end,
    input  logic [AMP_BITS-1:0]   delay_level,
    input  logic [TIME_BITS-1:0]  attack_end,
    input  logic [AMP_BITS-1:0]   attack_level,
    input  logic [TIME_BITS-1:0]  decay_end,
    input  logic [AMP_BITS-1:0]   sustain_level,
    input  logic [TIME_BITS-1:0]  release_length,
    input  logic [AMP_BITS-1:0]   release_level,
    // downstream side
    output logic                  out_valid,
    input  logic                  out_ready,
    output adsr_pkg::phase_t      out_phase,
    output logic [AMP_BITS-1:0]   out_base,
    output logic                  out_neg,
    output logic [AMP_BITS-1:0]   out_mag,
    output logic [TIME_BITS-1:0]  out_num,
    output logic [TIME_BITS-1:0]  out_den
);

    logic                  valid_reg;
    adsr_pkg::phase_t      phase_reg, phase_next;
    logic [AMP_BITS-1:0]   base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic [AMP_BITS-1:0]   mag_reg, mag_next;
    logic [TIME_BITS-1:0]  num_reg, num_next;
    logic [TIME_BITS-1:0]  den_reg, den_next;

    logic [AMP_BITS-1:0]   target;
    logic [TIME_BITS-1:0]  dur_eff;
    logic [TIME_BITS:0]    rel_end;
    logic                  load;

    // Take a new transaction when empty or when the held one moves on
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Raise the note length to the decay end and form the release end unwrapped
    assign dur_eff = (in_length < decay_end) ? decay_end : in_length;
    assign rel_end = {1'b0, dur_eff} + {1'b0, release_length};

    // Select the segment; flat segments get a zero step over a unit span
    always_comb begin
        phase_next = adsr_pkg::PH_FINISHED;
        base_next  = '0;
        target     = '0;
        num_next   = '0;
        den_next   = TIME_BITS'(1);
        if (in_time < delay_end) begin
            phase_next = adsr_pkg::PH_DELAY;
        end else if (in_time < attack_end) begin
            phase_next = adsr_pkg::PH_ATTACK;
            base_next  = delay_level;
            target     = attack_level;
            num_next   = in_time - delay_end;
            den_next   = attack_end - delay_end;
        end else if (in_time < decay_end) begin
            phase_next = adsr_pkg::PH_DECAY;
            base_next  = attack_level;
            target     = sustain_level;
            num_next   = in_time - attack_end;
            den_next   = decay_end - attack_end;
        end else if (in_time < dur_eff) begin
            phase_next = adsr_pkg::PH_SUSTAIN;
            base_next  = sustain_level;
            target     = sustain_level;
        end else if ({1'b0, in_time} < rel_end) begin
            phase_next = adsr_pkg::PH_RELEASE;
            base_next  = sustain_level;
            target     = release_level;
            num_next   = in_time - dur_eff;
            den_next   = release_length;
        end
    end

    // Split the level difference into direction and magnitude
    assign neg_next = target < base_next;
    assign mag_next = neg_next ? (base_next - target) : (target - base_next);

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Capture the payload
    always_ff @(posedge aclk) begin
        if (load) begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_phase = phase_reg;
    assign out_base  = base_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = mag_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

    // Every span handed to the divider is nonzero and exceeds its numerator
    `ADSR_ASSERT_NOW(a_front_num_below_den, aclk, aresetn, valid_reg, num_reg < den_reg)

endmodule

// ===== rtl/adsr_div_cell.sv =====
// ----------------------------------------------------------------------------
// adsr_div_cell
// One restoring-division cell: shifts in one dividend bit, trial-subtracts
// the span and produces one quotient bit, then hands on to the next cell.
// ----------------------------------------------------------------------------
`include "adsr_envelope_evaluator_defines.svh"

module adsr_div_cell #(
    parameter int TIME_BITS = 24,
    parameter int AMP_BITS  = 16,
    parameter int SIDE_W    = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_BITS-1:0]  in_rem,
    input  logic [AMP_BITS-1:0]   in_lq,
    input  logic [TIME_BITS-1:0]  in_den,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TIME_BITS-1:0]  out_rem,
    output logic [AMP_BITS-1:0]   out_lq,
    output logic [TIME_BITS-1:0]  out_den,
    output logic [SIDE_W-1:0]     out_side
);

    logic                  valid_reg;
    logic [TIME_BITS-1:0]  rem_reg, rem_next;
    logic [AMP_BITS-1:0]   lq_reg, lq_next;
    logic [TIME_BITS-1:0]  den_reg;
    logic [SIDE_W-1:0]     side_reg;

    logic [TIME_BITS:0]    trial;
    logic [TIME_BITS:0]    diff;
    logic                  fits;

    assign in_ready = !valid_reg || out_ready;

    // Shift the next dividend bit into the remainder and trial-subtract
    assign trial    = {in_rem, in_lq[AMP_BITS-1]};
    assign diff     = trial - {1'b0, in_den};
    assign fits     = !diff[TIME_BITS];
    assign rem_next = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    assign lq_next  = {in_lq[AMP_BITS-2:0], fits};

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rem_reg  <= rem_next;
            lq_reg   <= lq_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_lq    = lq_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

    // The partial remainder always stays below the divisor
    `ADSR_ASSERT_NOW(a_cell_rem_below_den, aclk, aresetn, valid_reg, rem_reg < den_reg)

endmodule

// ===== rtl/adsr_envelope_evaluator.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_evaluator
// Piecewise linear delay/attack/decay/sustain/release envelope, evaluated
// per sample time through a phase decode, a multiply and a division chain.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: sample_time, note_length
//  m_axis   | out       | tdata: amplitude; tuser: phase_code
//  cfg      | in        | cfg_addr selects register, cfg_wdata value
//
// One transaction per clock is taken and one result per clock is given while
// m_axis_tready is high. Stages: phase decode, multiply, one division cell
// per quotient bit (AMP_BITS cells), and the output register.
// Every stage holds its own valid flag, so an empty stage fills even while
// the result register is stalled; s_axis_tready falls only when all are full.
// aresetn clears all valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
`include "adsr_envelope_evaluator_defines.svh"

module adsr_envelope_evaluator #(
    parameter int TIME_BITS = 24,
    parameter int AMP_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [((TIME_BITS > AMP_BITS) ? TIME_BITS : AMP_BITS)-1:0] cfg_wdata,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: [TIME_BITS-1:0] sample_time, [2*TIME_BITS-1:TIME_BITS] note_length
    input  logic [((2*TIME_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: [AMP_BITS-1:0] amplitude
    output logic [((AMP_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // tuser: [2:0] phase_code
    output logic [adsr_pkg::PHASE_W-1:0]           m_axis_tuser
);

    localparam int OUT_W  = ((AMP_BITS + 7) / 8) * 8;
    localparam int PROD_W = AMP_BITS + TIME_BITS;
    localparam int SIDE_W = adsr_pkg::PHASE_W + 1 + AMP_BITS;

    // Configuration registers
    logic [TIME_BITS-1:0] delay_end_reg;
    logic [AMP_BITS-1:0]  delay_level_reg;
    logic [TIME_BITS-1:0] attack_end_reg;
    logic [AMP_BITS-1:0]  attack_level_reg;
    logic [TIME_BITS-1:0] decay_end_reg;
    logic [AMP_BITS-1:0]  sustain_level_reg;
    logic [TIME_BITS-1:0] release_length_reg;
    logic [AMP_BITS-1:0]  release_level_reg;

    // Write one register per enabled cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_end_reg      <= '0;
            delay_level_reg    <= '0;
            attack_end_reg     <= '0;
            attack_level_reg   <= adsr_pkg::HALF_SCALE[AMP_BITS-1:0];
            decay_end_reg      <= '0;
            sustain_level_reg  <= adsr_pkg::HALF_SCALE[AMP_BITS-1:0];
            release_length_reg <= '0;
            release_level_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (adsr_pkg::cfg_reg_t'(cfg_addr))
                adsr_pkg::REG_DELAY_END:      delay_end_reg      <= cfg_wdata[TIME_BITS-1:0];
                adsr_pkg::REG_DELAY_LEVEL:    delay_level_reg    <= cfg_wdata[AMP_BITS-1:0];
                adsr_pkg::REG_ATTACK_END:     attack_end_reg     <= cfg_wdata[TIME_BITS-1:0];
                adsr_pkg::REG_ATTACK_LEVEL:   attack_level_reg   <= cfg_wdata[AMP_BITS-1:0];
                adsr_pkg::REG_DECAY_END:      decay_end_reg      <= cfg_wdata[TIME_BITS-1:0];
                adsr_pkg::REG_SUSTAIN_LEVEL:  sustain_level_reg  <= cfg_wdata[AMP_BITS-1:0];
                adsr_pkg::REG_RELEASE_LENGTH: release_length_reg <= cfg_wdata[TIME_BITS-1:0];
                adsr_pkg::REG_RELEASE_LEVEL:  release_level_reg  <= cfg_wdata[AMP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Phase decode stage
    logic                  fr_valid, fr_ready;
    adsr_pkg::phase_t      fr_phase;
    logic [AMP_BITS-1:0]   fr_base;
    logic                  fr_neg;
    logic [AMP_BITS-1:0]   fr_mag;
    logic [TIME_BITS-1:0]  fr_num;
    logic [TIME_BITS-1:0]  fr_den;

    adsr_front #(
        .TIME_BITS (TIME_BITS),
        .AMP_BITS  (AMP_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_time        (s_axis_tdata[TIME_BITS-1:0]),
        .in_length      (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
        .delay_end      (delay_end_reg),
        .delay_level    (delay_level_reg),
        .attack_end     (attack_end_reg),
        .attack_level   (attack_level_reg),
        .decay_end      (decay_end_reg),
        .sustain_level  (sustain_level_reg),
        .release_length (release_length_reg),
        .release_level  (release_level_reg),
        .out_valid      (fr_valid),
        .out_ready      (fr_ready),
        .out_phase      (fr_phase),
        .out_base       (fr_base),
        .out_neg        (fr_neg),
        .out_mag        (fr_mag),
        .out_num        (fr_num),
        .out_den        (fr_den)
    );

    // Multiply stage: step magnitude times elapsed samples
    logic                  mul_valid_reg;
    logic [PROD_W-1:0]     mul_prod_reg;
    logic [TIME_BITS-1:0]  mul_den_reg;
    logic [SIDE_W-1:0]     mul_side_reg;

    // Division chain links, one per cell boundary
    logic                  ch_valid [0:AMP_BITS];
    logic                  ch_ready [0:AMP_BITS];
    logic [TIME_BITS-1:0]  ch_rem   [0:AMP_BITS];
    logic [AMP_BITS-1:0]   ch_lq    [0:AMP_BITS];
    logic [TIME_BITS-1:0]  ch_den   [0:AMP_BITS];
    logic [SIDE_W-1:0]     ch_side  [0:AMP_BITS];

    assign fr_ready = !mul_valid_reg || ch_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (fr_ready) begin
            mul_valid_reg <= fr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fr_valid && fr_ready) begin
            mul_prod_reg <= {{TIME_BITS{1'b0}}, fr_mag} * {{AMP_BITS{1'b0}}, fr_num};
            mul_den_reg  <= fr_den;
            mul_side_reg <= {fr_phase, fr_neg, fr_base};
        end
    end

    // Upper product bits seed the remainder, lower bits shift in per cell
    assign ch_valid[0] = mul_valid_reg;
    assign ch_rem[0]   = mul_prod_reg[PROD_W-1:AMP_BITS];
    assign ch_lq[0]    = mul_prod_reg[AMP_BITS-1:0];
    assign ch_den[0]   = mul_den_reg;
    assign ch_side[0]  = mul_side_reg;

    for (genvar i = 0; i < AMP_BITS; i++) begin : g_cell
        adsr_div_cell #(
            .TIME_BITS (TIME_BITS),
            .AMP_BITS  (AMP_BITS),
            .SIDE_W    (SIDE_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_rem    (ch_rem[i]),
            .in_lq     (ch_lq[i]),
            .in_den    (ch_den[i]),
            .in_side   (ch_side[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_rem   (ch_rem[i+1]),
            .out_lq    (ch_lq[i+1]),
            .out_den   (ch_den[i+1]),
            .out_side  (ch_side[i+1])
        );
    end

    // Output stage: apply the quotient to the ramp start
    logic                  out_valid_reg;
    logic [AMP_BITS-1:0]   out_amp_reg, out_amp_next;
    adsr_pkg::phase_t      out_phase_reg;
    logic [AMP_BITS-1:0]   q_base;
    logic                  q_neg;
    logic [AMP_BITS-1:0]   quot;

    assign q_base       = ch_side[AMP_BITS][AMP_BITS-1:0];
    assign q_neg        = ch_side[AMP_BITS][AMP_BITS];
    assign quot         = ch_lq[AMP_BITS];
    assign out_amp_next = q_neg ? (q_base - quot) : (q_base + quot);

    assign ch_ready[AMP_BITS] = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ch_ready[AMP_BITS]) begin
            out_valid_reg <= ch_valid[AMP_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ch_valid[AMP_BITS] && ch_ready[AMP_BITS]) begin
            out_amp_reg   <= out_amp_next;
            out_phase_reg <= adsr_pkg::phase_t'(ch_side[AMP_BITS][SIDE_W-1:AMP_BITS+1]);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_amp_reg);
    assign m_axis_tuser  = out_phase_reg;

    // Silent phases carry zero amplitude
    `ADSR_ASSERT_NOW(a_top_silent_zero, aclk, aresetn,
        m_axis_tvalid && (out_phase_reg == adsr_pkg::PH_DELAY ||
                          out_phase_reg == adsr_pkg::PH_FINISHED),
        out_amp_reg == '0)

    // Input backpressure only when the whole chain, result included, is full
    `ADSR_ASSERT_NOW(a_top_stall_full, aclk, aresetn, !s_axis_tready, m_axis_tvalid)

    // A stalled result stays valid in the next cycle
    `ADSR_ASSERT_NEXT(a_top_result_kept, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule
